FILE: hw/rtl/w2td_pkg.sv
package w2td_pkg;

  // Longest UIntBase128 value, in bytes.
  localparam logic [2:0] MAX_VARINT_BYTES = 3'd5;
  // Bytes in an explicit tag.
  localparam logic [2:0] TAG_BYTES = 3'd4;

  // Flag byte low six bits that announce an explicit tag.
  localparam logic [5:0] TAG_CODE_EXPLICIT = 6'h3f;

  localparam logic [31:0] TAG_GLYF = 32'h676c7966;
  localparam logic [31:0] TAG_LOCA = 32'h6c6f6361;

  // Configuration register indexes.
  localparam logic [0:0] REG_GLYF_KNOWN_INDEX = 1'b0;
  localparam logic [0:0] REG_LOCA_KNOWN_INDEX = 1'b1;

  // Error codes reported with a result.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_LEADING  = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW = 3'd2;
  localparam logic [2:0] ERR_TOO_LONG = 3'd3;
  localparam logic [2:0] ERR_LOCA     = 3'd4;
  localparam logic [2:0] ERR_WRAP     = 3'd5;

  typedef enum logic [3:0] {
    PH_FLAG = 4'b0001,
    PH_TAG  = 4'b0010,
    PH_LEN1 = 4'b0100,
    PH_LEN2 = 4'b1000
  } phase_t;

endpackage

FILE: hw/rtl/woff2_table_directory_parser_unit.sv
// Table directory parser for a compressed font container. Directory bytes
// arrive one per request on the input channel; an entry is a flag byte, an
// optional four-byte explicit tag (flag low bits all ones) and one or two
// UIntBase128 lengths, the second only for transformed entries. When the last
// byte of an entry is taken, one result request carries the tag code, tag,
// version, transform flag, both lengths, the running source offset and an
// error code. The block takes one byte every clock cycle unless the input
// stalls: each byte passes through a single level of decode logic into the
// state registers, and the result of the byte that finishes an entry is held
// in a single output register. The input stalls only while that register holds
// a result that the downstream side is stalling. After an error result no
// further results appear until a byte arrives with restart set; that byte is
// taken as a new flag byte and clears the running offset. The two configuration
// registers select which six-bit known-tag codes name the glyf and loca tables;
// the user is to write them only while the block is idle; the block does not enforce it.
module woff2_table_directory_parser_unit
  import w2td_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [5:0]  cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        restart,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  tag_code,
  output logic [31:0] explicit_tag,
  output logic [1:0]  table_version,
  output logic        is_transformed,
  output logic [31:0] orig_length,
  output logic [31:0] transform_length,
  output logic [31:0] source_offset,
  output logic [2:0]  error_code
);

  // Configuration registers.
  logic [5:0] glyf_known_index;
  logic [5:0] loca_known_index;

  // Parser state.
  phase_t      phase, phase_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [7:0]  held_flag, held_flag_next;
  logic [31:0] tag_accum, tag_accum_next;
  logic [31:0] varint_accum, varint_accum_next;
  logic [31:0] held_orig_length, held_orig_length_next;
  logic [31:0] running_offset, running_offset_next;
  logic        halted, halted_next;

  // Result produced by the byte being accepted.
  logic        emit;
  logic [2:0]  emit_err;
  logic [31:0] emit_orig;
  logic [31:0] emit_tlen;

  logic        in_accept;
  logic        proceed;
  phase_t      cur_phase;

  // The output register can take a new result unless it is full and stalled.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign proceed   = in_accept && (restart || !halted);
  assign cur_phase = restart ? PH_FLAG : phase;

  // Attributes of the entry in progress. They come from the held flag byte
  // and the collected tag, which are stable throughout the length bytes.
  logic [5:0] entry_code;
  logic [1:0] entry_version;
  logic       entry_is_glyf;
  logic       entry_is_loca;
  logic       entry_transformed;

  assign entry_code    = held_flag[5:0];
  assign entry_version = held_flag[7:6];

  always_comb begin
    if (entry_code == TAG_CODE_EXPLICIT) begin
      entry_is_glyf = (tag_accum == TAG_GLYF);
      entry_is_loca = (tag_accum == TAG_LOCA);
    end else begin
      entry_is_glyf = (entry_code == glyf_known_index);
      entry_is_loca = (entry_code == loca_known_index);
    end
    // glyf and loca are transformed by default; every other table is
    // transformed only when asked for by a nonzero version.
    if (entry_is_glyf || entry_is_loca) begin
      entry_transformed = (entry_version == 2'd0);
    end else begin
      entry_transformed = (entry_version != 2'd0);
    end
  end

  // One UIntBase128 byte step: the overflow test looks at the accumulator
  // before the shift, so a value needing more than 32 bits is caught.
  logic        vi_leading;
  logic        vi_overflow;
  logic [31:0] vi_shifted;
  logic [2:0]  count_inc;
  logic [32:0] offset_sum;
  logic [31:0] fin_orig;
  logic        fin_loca_bad;
  logic        fin_wrap;

  assign vi_leading  = (byte_count == 3'd0) && (data_byte == 8'h80);
  assign vi_overflow = |varint_accum[31:25];
  assign vi_shifted  = {varint_accum[24:0], data_byte[6:0]};
  assign count_inc   = byte_count + 3'd1;

  // Finishing an entry: the finished length is always the value just
  // decoded. In the first length it is also the original length.
  assign fin_orig     = (cur_phase == PH_LEN1) ? vi_shifted : held_orig_length;
  assign offset_sum   = {1'b0, running_offset} + {1'b0, vi_shifted};
  assign fin_wrap     = offset_sum[32];
  assign fin_loca_bad = (cur_phase == PH_LEN2) && entry_is_loca && (vi_shifted != 32'd0);

  always_comb begin
    phase_next            = phase;
    byte_count_next       = byte_count;
    held_flag_next        = held_flag;
    tag_accum_next        = tag_accum;
    varint_accum_next     = varint_accum;
    held_orig_length_next = held_orig_length;
    running_offset_next   = running_offset;
    halted_next           = halted;
    emit                  = 1'b0;
    emit_err              = ERR_NONE;
    emit_orig             = 32'd0;
    emit_tlen             = 32'd0;

    if (in_accept && restart) begin
      halted_next         = 1'b0;
      running_offset_next = 32'd0;
      phase_next          = PH_FLAG;
    end

    if (proceed) begin
      unique case (cur_phase) inside
        PH_FLAG: begin
          held_flag_next        = data_byte;
          tag_accum_next        = 32'd0;
          byte_count_next       = 3'd0;
          varint_accum_next     = 32'd0;
          held_orig_length_next = 32'd0;
          phase_next = (data_byte[5:0] == TAG_CODE_EXPLICIT) ? PH_TAG : PH_LEN1;
        end
        PH_TAG: begin
          tag_accum_next  = {tag_accum[23:0], data_byte};
          byte_count_next = count_inc;
          if (count_inc >= TAG_BYTES) begin
            byte_count_next = 3'd0;
            phase_next      = PH_LEN1;
          end
        end
        PH_LEN1, PH_LEN2: begin
          if (vi_leading || vi_overflow) begin
            emit        = 1'b1;
            emit_err    = vi_leading ? ERR_LEADING : ERR_OVERFLOW;
            emit_orig   = (cur_phase == PH_LEN1) ? 32'd0 : held_orig_length;
            halted_next = 1'b1;
          end else begin
            varint_accum_next = vi_shifted;
            if (data_byte[7]) begin
              byte_count_next = count_inc;
              if (count_inc >= MAX_VARINT_BYTES) begin
                emit        = 1'b1;
                emit_err    = ERR_TOO_LONG;
                emit_orig   = (cur_phase == PH_LEN1) ? 32'd0 : held_orig_length;
                halted_next = 1'b1;
              end
            end else if ((cur_phase == PH_LEN1) && entry_transformed) begin
              held_orig_length_next = vi_shifted;
              byte_count_next       = 3'd0;
              varint_accum_next     = 32'd0;
              phase_next            = PH_LEN2;
            end else begin
              held_orig_length_next = fin_orig;
              emit      = 1'b1;
              emit_orig = fin_orig;
              emit_tlen = vi_shifted;
              if (fin_loca_bad) begin
                emit_err    = ERR_LOCA;
                halted_next = 1'b1;
              end else if (fin_wrap) begin
                emit_err    = ERR_WRAP;
                halted_next = 1'b1;
              end else begin
                running_offset_next = offset_sum[31:0];
                phase_next          = PH_FLAG;
              end
            end
          end
        end
        default: begin
          phase_next = PH_FLAG;
        end
      endcase
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      glyf_known_index <= 6'd10;
      loca_known_index <= 6'd11;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GLYF_KNOWN_INDEX: glyf_known_index <= cfg_data;
        REG_LOCA_KNOWN_INDEX: loca_known_index <= cfg_data;
        default: ;
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_FLAG;
      byte_count       <= 3'd0;
      held_flag        <= 8'd0;
      tag_accum        <= 32'd0;
      varint_accum     <= 32'd0;
      held_orig_length <= 32'd0;
      running_offset   <= 32'd0;
      halted           <= 1'b0;
    end else begin
      phase            <= phase_next;
      byte_count       <= byte_count_next;
      held_flag        <= held_flag_next;
      tag_accum        <= tag_accum_next;
      varint_accum     <= varint_accum_next;
      held_orig_length <= held_orig_length_next;
      running_offset   <= running_offset_next;
      halted           <= halted_next;
    end
  end

  // Output register. A new result is loaded only when the register is empty
  // or being drained in this cycle, which the input stall guarantees.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tag_code         <= entry_code;
      explicit_tag     <= (entry_code == TAG_CODE_EXPLICIT) ? tag_accum : 32'd0;
      table_version    <= entry_version;
      is_transformed   <= entry_transformed;
      orig_length      <= emit_orig;
      transform_length <= emit_tlen;
      source_offset    <= running_offset;
      error_code       <= emit_err;
    end
  end

endmodule

FILE: hw/rtl/w2td_checker.sv
module w2td_checker
  import w2td_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  tag_code,
  input logic [31:0] explicit_tag,
  input logic        is_transformed,
  input logic [31:0] orig_length,
  input logic [31:0] transform_length,
  input logic [31:0] source_offset,
  input logic [2:0]  error_code
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(orig_length)
      && $stable(transform_length) && $stable(source_offset) && $stable(error_code))
    else $error("stalled result changed");

  // No byte is taken while a finished result is waiting and stalled.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && out_stall |-> in_stall)
    else $error("byte accepted while output register is blocked");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> error_code <= ERR_WRAP)
    else $error("undefined error code");

  // A clean untransformed entry reports its original length twice.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ERR_NONE && !is_transformed
      |-> transform_length == orig_length)
    else $error("untransformed entry lengths differ");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && tag_code != TAG_CODE_EXPLICIT |-> explicit_tag == 32'd0)
    else $error("explicit tag shown for a known-tag entry");

endmodule

bind woff2_table_directory_parser_unit w2td_checker u_w2td_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .tag_code         (tag_code),
  .explicit_tag     (explicit_tag),
  .is_transformed   (is_transformed),
  .orig_length      (orig_length),
  .transform_length (transform_length),
  .source_offset    (source_offset),
  .error_code       (error_code)
);
